/* hdl/wmss_pkg.sv */
// ============================================================================
// wmss_pkg
// Shared types and constants of the WebAssembly module section scanner.
// ============================================================================
`default_nettype none

package wmss_pkg;

  typedef enum logic [3:0] {
    ERR_OK        = 4'd0,
    ERR_HEADER    = 4'd1,
    ERR_LEB_WIDTH = 4'd2,
    ERR_TRUNC     = 4'd3,
    ERR_PAST_END  = 4'd4,
    ERR_IMP_KIND  = 4'd5,
    ERR_IMPORT    = 4'd6,
    ERR_FUNCTION  = 4'd7,
    ERR_EXPORT    = 4'd8,
    ERR_NO_FUNC   = 4'd9
  } err_e;

  localparam logic [7:0] SEC_IMPORT   = 8'h02;
  localparam logic [7:0] SEC_FUNCTION = 8'h03;
  localparam logic [7:0] SEC_EXPORT   = 8'h07;

  localparam logic [7:0] KIND_FUNC   = 8'h00;
  localparam logic [7:0] KIND_TABLE  = 8'h01;
  localparam logic [7:0] KIND_MEMORY = 8'h02;
  localparam logic [7:0] KIND_GLOBAL = 8'h03;
  localparam logic [7:0] KIND_TAG    = 8'h04;

  localparam logic [3:0] NO_MATCH = 4'd15;
  localparam logic [3:0] NAME_LEN = 4'd4;

  typedef struct packed {
    err_e        err_code;
    logic [31:0] imported_functions;
    logic [31:0] defined_functions;
    logic        has_main_export;
  } res_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] pos);
    case (pos)
      3'd1:    magic_byte = 8'h61;
      3'd2:    magic_byte = 8'h73;
      3'd3:    magic_byte = 8'h6D;
      3'd4:    magic_byte = 8'h01;
      default: magic_byte = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] main_char(input logic [1:0] pos);
    case (pos)
      2'd0:    main_char = 8'h6D;
      2'd1:    main_char = 8'h61;
      2'd2:    main_char = 8'h69;
      default: main_char = 8'h6E;
    endcase
  endfunction

endpackage

`default_nettype wire

/* hdl/wmss_in_if.sv */
// ============================================================================
// wmss_in_if
// Byte channel into the scanner: valid/ready with one module byte per item.
// ============================================================================
`default_nettype none

interface wmss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

`default_nettype wire

/* hdl/wmss_out_if.sv */
// ============================================================================
// wmss_out_if
// Result channel of the scanner: one summary item per module.
// ============================================================================
`default_nettype none

interface wmss_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  err_code;
  logic [31:0] imported_functions;
  logic [31:0] defined_functions;
  logic        has_main_export;
  logic [31:0] main_index;

  modport source (output valid, output err_code, output imported_functions,
                  output defined_functions, output has_main_export,
                  output main_index, input ready);
  modport sink   (input valid, input err_code, input imported_functions,
                  input defined_functions, input has_main_export,
                  input main_index, output ready);
endinterface

`default_nettype wire

/* hdl/wasm_module_section_scanner.sv */
// ============================================================================
// wasm_module_section_scanner
// Scans a WebAssembly module byte stream and reports counts, main export, error.
// ============================================================================
// Throughput: one byte per cycle; a held result leaves in the same cycle a byte enters.
// Latency: the summary item is valid the cycle after the last byte is taken.
// A byte stalls only while a result is held and the output is not ready.
// Reset (async, active low) clears all parser state; no clearing pass.
`default_nettype none

module wasm_module_section_scanner
  import wmss_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wmss_in_if.sink    in_i,
  wmss_out_if.source out_o
);

  logic accept;
  logic res_fire;
  res_t res;
  res_t res_q;
  logic vld_q, vld_d;

  assign in_i.ready = !vld_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  wmss_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .byte_i     (in_i.byte_value),
    .last_i     (in_i.last_byte),
    .res_fire_o (res_fire),
    .res_o      (res)
  );

  always_comb begin
    vld_d = vld_q;
    if (res_fire) begin
      vld_d = 1'b1;
    end else if (out_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      res_q <= res;
    end
  end

  assign out_o.valid              = vld_q;
  assign out_o.err_code           = res_q.err_code;
  assign out_o.imported_functions = res_q.imported_functions;
  assign out_o.defined_functions  = res_q.defined_functions;
  assign out_o.has_main_export    = res_q.has_main_export;
  assign out_o.main_index         = res_q.imported_functions
                                  + res_q.defined_functions - 32'd1;

endmodule

`default_nettype wire

/* hdl/wmss_core.sv */
// ============================================================================
// wmss_core
// Byte-wise parser state: header check, ULEB128 decode, section walk.
// ============================================================================
`default_nettype none

module wmss_core
  import wmss_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output logic            res_fire_o,
  output res_t            res_o
);

  typedef enum logic [4:0] {
    PH_HDR, PH_SEC_ID, PH_SEC_SIZE, PH_SKIP, PH_DONE,
    PH_IMP_COUNT, PH_IMP_MODLEN, PH_IMP_MODSTR, PH_IMP_FLDLEN, PH_IMP_FLDSTR,
    PH_IMP_KIND, PH_IMP_FUNC_TYPE, PH_IMP_TABLE_REF, PH_IMP_LIM_FLAGS,
    PH_IMP_LIM_MIN, PH_IMP_LIM_MAX, PH_IMP_GLOBAL, PH_IMP_TAG_ATTR,
    PH_IMP_TAG_TYPE, PH_FN_COUNT, PH_FN_TYPE, PH_EX_COUNT, PH_EX_NAMELEN,
    PH_EX_NAME, PH_EX_KIND, PH_EX_INDEX
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  hpos_q, hpos_d;
  logic [7:0]  skind_q, skind_d;
  logic [31:0] sec_left_q, sec_left_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  lidx_q, lidx_d;     // ULEB byte index, 7 bits each, 4 bits in the fifth byte
  logic [31:0] items_q, items_d;
  logic [31:0] str_q, str_d;
  logic [7:0]  ekind_q, ekind_d;
  logic        has_max_q, has_max_d;
  logic [3:0]  nmp_q, nmp_d;
  logic [31:0] imp_q, imp_d;
  logic [31:0] def_q, def_d;
  logic        main_q, main_d;
  err_e        err_q, err_d;

  logic [31:0] part;
  logic [31:0] leb_val;
  logic        leb_wide;
  logic        leb_fin;
  err_e        sec_err;

  always_comb begin
    case (lidx_q)
      3'd0:    part = {25'd0, byte_i[6:0]};
      3'd1:    part = {18'd0, byte_i[6:0], 7'd0};
      3'd2:    part = {11'd0, byte_i[6:0], 14'd0};
      3'd3:    part = {4'd0, byte_i[6:0], 21'd0};
      default: part = {byte_i[3:0], 28'd0};
    endcase
    leb_val  = acc_q | part;
    leb_wide = (lidx_q >= 3'd4) && (byte_i[7:4] != 4'd0);
    leb_fin  = (lidx_q >= 3'd4) || !byte_i[7];
    if (skind_q == SEC_IMPORT) begin
      sec_err = ERR_IMPORT;
    end else if (skind_q == SEC_FUNCTION) begin
      sec_err = ERR_FUNCTION;
    end else begin
      sec_err = ERR_EXPORT;
    end
  end

  always_comb begin
    phase_d = phase_q;   hpos_d = hpos_q;   skind_d = skind_q;
    sec_left_d = sec_left_q; acc_d = acc_q; lidx_d = lidx_q;
    items_d = items_q;   str_d = str_q;     ekind_d = ekind_q;
    has_max_d = has_max_q; nmp_d = nmp_q;   imp_d = imp_q;
    def_d = def_q;       main_d = main_q;   err_d = err_q;
    res_fire_o = 1'b0;
    res_o = '0;

    if (accept_i) begin
      if (err_q == ERR_OK) begin
        case (phase_q)
          PH_HDR: begin
            if (byte_i != magic_byte(hpos_q)) begin
              err_d = ERR_HEADER;
            end else if (hpos_q == 3'd7) begin
              phase_d = PH_SEC_ID;
            end else begin
              hpos_d = hpos_q + 3'd1;
            end
          end
          PH_SEC_ID: begin
            skind_d = byte_i;
            phase_d = PH_SEC_SIZE;
          end
          PH_SEC_SIZE: begin
            if (leb_wide) begin
              err_d = ERR_LEB_WIDTH;
            end else if (leb_fin) begin
              acc_d = '0;
              lidx_d = '0;
              sec_left_d = leb_val;
              if (skind_q == SEC_IMPORT) begin
                imp_d = '0;
                phase_d = PH_IMP_COUNT;
              end else if (skind_q == SEC_FUNCTION) begin
                phase_d = PH_FN_COUNT;
              end else if (skind_q == SEC_EXPORT) begin
                main_d = 1'b0;
                phase_d = PH_EX_COUNT;
              end else begin
                phase_d = PH_SKIP;
              end
              if (leb_val == '0) begin
                if (phase_d != PH_SKIP) begin
                  err_d = sec_err;
                end else begin
                  phase_d = PH_SEC_ID;
                end
              end
            end else begin
              acc_d = leb_val;
              lidx_d = lidx_q + 3'd1;
            end
          end
          default: begin
            if (phase_q inside {PH_IMP_COUNT, PH_IMP_MODLEN, PH_IMP_FLDLEN,
                                PH_IMP_FUNC_TYPE, PH_IMP_LIM_FLAGS, PH_IMP_LIM_MIN,
                                PH_IMP_LIM_MAX, PH_IMP_TAG_TYPE, PH_FN_COUNT,
                                PH_FN_TYPE, PH_EX_COUNT, PH_EX_NAMELEN,
                                PH_EX_INDEX}) begin
              if (leb_wide) begin
                err_d = ERR_LEB_WIDTH;
              end else if (leb_fin) begin
                acc_d = '0;
                lidx_d = '0;
                case (phase_q)
                  PH_IMP_COUNT: begin
                    items_d = leb_val;
                    phase_d = (leb_val != '0) ? PH_IMP_MODLEN : PH_DONE;
                  end
                  PH_IMP_MODLEN: begin
                    str_d = (leb_val != '0) ? leb_val : str_q;
                    phase_d = (leb_val != '0) ? PH_IMP_MODSTR : PH_IMP_FLDLEN;
                  end
                  PH_IMP_FLDLEN: begin
                    str_d = (leb_val != '0) ? leb_val : str_q;
                    phase_d = (leb_val != '0) ? PH_IMP_FLDSTR : PH_IMP_KIND;
                  end
                  PH_IMP_FUNC_TYPE: begin
                    imp_d = imp_q + 32'd1;
                    items_d = items_q - 32'd1;
                    phase_d = (items_q != 32'd1) ? PH_IMP_MODLEN : PH_DONE;
                  end
                  PH_IMP_LIM_FLAGS: begin
                    has_max_d = leb_val[0];
                    phase_d = PH_IMP_LIM_MIN;
                  end
                  PH_IMP_LIM_MIN: begin
                    if (has_max_q) begin
                      phase_d = PH_IMP_LIM_MAX;
                    end else begin
                      items_d = items_q - 32'd1;
                      phase_d = (items_q != 32'd1) ? PH_IMP_MODLEN : PH_DONE;
                    end
                  end
                  PH_IMP_LIM_MAX, PH_IMP_TAG_TYPE: begin
                    items_d = items_q - 32'd1;
                    phase_d = (items_q != 32'd1) ? PH_IMP_MODLEN : PH_DONE;
                  end
                  PH_FN_COUNT: begin
                    def_d = leb_val;
                    items_d = leb_val;
                    phase_d = (leb_val != '0) ? PH_FN_TYPE : PH_DONE;
                  end
                  PH_FN_TYPE: begin
                    items_d = items_q - 32'd1;
                    phase_d = (items_q != 32'd1) ? PH_FN_TYPE : PH_DONE;
                  end
                  PH_EX_COUNT: begin
                    items_d = leb_val;
                    phase_d = (leb_val != '0) ? PH_EX_NAMELEN : PH_DONE;
                  end
                  PH_EX_NAMELEN: begin
                    nmp_d = (leb_val == 32'd4) ? 4'd0 : NO_MATCH;
                    str_d = (leb_val != '0) ? leb_val : str_q;
                    phase_d = (leb_val != '0) ? PH_EX_NAME : PH_EX_KIND;
                  end
                  default: begin
                    if (ekind_q == KIND_FUNC && nmp_q == NAME_LEN) begin
                      main_d = 1'b1;
                    end
                    items_d = items_q - 32'd1;
                    phase_d = (items_q != 32'd1) ? PH_EX_NAMELEN : PH_DONE;
                  end
                endcase
              end else begin
                acc_d = leb_val;
                lidx_d = lidx_q + 3'd1;
              end
            end else begin
              case (phase_q)
                PH_SKIP: ;
                PH_DONE: err_d = sec_err;
                PH_IMP_MODSTR: begin
                  str_d = str_q - 32'd1;
                  if (str_q == 32'd1) phase_d = PH_IMP_FLDLEN;
                end
                PH_IMP_FLDSTR: begin
                  str_d = str_q - 32'd1;
                  if (str_q == 32'd1) phase_d = PH_IMP_KIND;
                end
                PH_IMP_KIND: begin
                  ekind_d = byte_i;
                  case (byte_i)
                    KIND_FUNC:   phase_d = PH_IMP_FUNC_TYPE;
                    KIND_TABLE:  phase_d = PH_IMP_TABLE_REF;
                    KIND_MEMORY: phase_d = PH_IMP_LIM_FLAGS;
                    KIND_GLOBAL: begin
                      str_d = 32'd2;
                      phase_d = PH_IMP_GLOBAL;
                    end
                    KIND_TAG:    phase_d = PH_IMP_TAG_ATTR;
                    default:     err_d = ERR_IMP_KIND;
                  endcase
                end
                PH_IMP_TABLE_REF: phase_d = PH_IMP_LIM_FLAGS;
                PH_IMP_GLOBAL: begin
                  str_d = str_q - 32'd1;
                  if (str_q == 32'd1) begin
                    items_d = items_q - 32'd1;
                    phase_d = (items_q != 32'd1) ? PH_IMP_MODLEN : PH_DONE;
                  end
                end
                PH_IMP_TAG_ATTR: phase_d = PH_IMP_TAG_TYPE;
                PH_EX_NAME: begin
                  if (nmp_q < NAME_LEN && byte_i == main_char(nmp_q[1:0])) begin
                    nmp_d = nmp_q + 4'd1;
                  end else begin
                    nmp_d = NO_MATCH;
                  end
                  str_d = str_q - 32'd1;
                  if (str_q == 32'd1) phase_d = PH_EX_KIND;
                end
                PH_EX_KIND: begin
                  ekind_d = byte_i;
                  phase_d = PH_EX_INDEX;
                end
                default: ;
              endcase
            end
            // payload byte counts against the section size
            if (err_d == ERR_OK) begin
              sec_left_d = sec_left_q - 32'd1;
              if (sec_left_q == 32'd1) begin
                if (phase_d != PH_SKIP && phase_d != PH_DONE) begin
                  err_d = sec_err;
                end else begin
                  phase_d = PH_SEC_ID;
                end
              end
            end
          end
        endcase
      end

      if (last_i) begin
        if (err_d == ERR_OK) begin
          if (phase_d == PH_HDR) begin
            err_d = ERR_HEADER;
          end else if (phase_d == PH_SEC_SIZE) begin
            err_d = ERR_TRUNC;
          end else if (phase_d != PH_SEC_ID) begin
            err_d = ERR_PAST_END;
          end
        end
        if (err_d == ERR_OK && def_d == '0) err_d = ERR_NO_FUNC;
        res_fire_o = 1'b1;
        res_o.err_code = err_d;
        res_o.imported_functions = imp_d;
        res_o.defined_functions = def_d;
        res_o.has_main_export = main_d;
        // back to reset state for the next module
        phase_d = PH_HDR;  hpos_d = '0;  skind_d = '0;  sec_left_d = '0;
        acc_d = '0;  lidx_d = '0;  items_d = '0;  str_d = '0;  ekind_d = '0;
        has_max_d = 1'b0;  nmp_d = '0;  imp_d = '0;  def_d = '0;
        main_d = 1'b0;  err_d = ERR_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;  hpos_q <= '0;  skind_q <= '0;  sec_left_q <= '0;
      acc_q <= '0;  lidx_q <= '0;  items_q <= '0;  str_q <= '0;  ekind_q <= '0;
      has_max_q <= 1'b0;  nmp_q <= '0;  imp_q <= '0;  def_q <= '0;
      main_q <= 1'b0;  err_q <= ERR_OK;
    end else begin
      phase_q <= phase_d;  hpos_q <= hpos_d;  skind_q <= skind_d;
      sec_left_q <= sec_left_d;  acc_q <= acc_d;  lidx_q <= lidx_d;
      items_q <= items_d;  str_q <= str_d;  ekind_q <= ekind_d;
      has_max_q <= has_max_d;  nmp_q <= nmp_d;  imp_q <= imp_d;
      def_q <= def_d;  main_q <= main_d;  err_q <= err_d;
    end
  end

endmodule

`default_nettype wire
